[hw/rtl/hss_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Hermite segment sampler.
package hss_pkg;

   localparam int COORD_BITS    = 16;
   localparam int STEPS_DEFAULT = 25;
   localparam int FRAC_BITS     = 16;
   localparam int WEIGHT_BITS   = FRAC_BITS + 2;
   localparam int PROD_BITS     = COORD_BITS + WEIGHT_BITS;
   localparam int SUM_BITS      = PROD_BITS + 3;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic                         curve_start;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] tangent_x;
      logic signed [COORD_BITS-1:0] tangent_y;
   } hss_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] from_x;
      logic signed [COORD_BITS-1:0] from_y;
      logic signed [COORD_BITS-1:0] to_x;
      logic signed [COORD_BITS-1:0] to_y;
      logic                         last_of_run;
   } hss_rsp_type;

   // queued point, already classified as curve start or segment end
   typedef struct packed {
      logic                         start;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] tangent_x;
      logic signed [COORD_BITS-1:0] tangent_y;
   } hss_entry_type;

   // Q2.16 basis weights h1..h4 for one t
   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] w1;
      logic signed [WEIGHT_BITS-1:0] w2;
      logic signed [WEIGHT_BITS-1:0] w3;
      logic signed [WEIGHT_BITS-1:0] w4;
   } hss_weight_type;

endpackage

[hw/rtl/hermite_segment_sampler.sv]
`timescale 1ns / 1ps
// Top level: cubic Hermite segment sampler, front queue plus sample pipeline.
//
//  channel  dir   ports                            word
//  req      in    req_valid/req_ready/req_data     one control point + tangent
//  rsp      out   rsp_valid/rsp_ready/rsp_data     one line (from, to, last)
//
// A segment point issues STEPS_PER_SEGMENT+1 samples (26 by default), one per
// cycle from the back end sequencer unless rsp stalls; a curve start point
// issues one silent sample. Samples pass registered weight, multiply, add, round.
// A two word queue lets points arrive while the back end is busy.
// Reset clears the queue, the t counter and all pipeline valids.
// A stalled rsp freezes the whole sample pipeline; the front keeps filling.
module hermite_segment_sampler import hss_pkg::*; #(
   parameter int STEPS_PER_SEGMENT = STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hss_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hss_rsp_type rsp_data
);

   logic          entry_valid;
   logic          entry_pop;
   hss_entry_type entry;

   hss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop)
   );

   hss_back #(
      .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

[hw/rtl/hss_front.sv]
`timescale 1ns / 1ps
// Front end: takes points, classifies them and queues them for the back end.
module hss_front import hss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  hss_req_type   req_data,
   output logic          entry_valid,
   output hss_entry_type entry,
   input  logic          entry_pop
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   hss_entry_type       q_ff [QUEUE_DEPTH];
   hss_entry_type       push_entry;
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                have_point_ff, have_point_in;
   logic                push, pop;

   assign req_ready   = (count_ff != CNT_FULL);
   assign push        = req_valid && req_ready;
   assign entry_valid = (count_ff != '0);
   assign pop         = entry_pop && entry_valid;
   assign entry       = q_ff[rd_ptr_ff];

   // a continuation with no stored point behaves as a curve start
   always_comb begin
      push_entry.start     = req_data.curve_start || !have_point_ff;
      push_entry.point_x   = req_data.point_x;
      push_entry.point_y   = req_data.point_y;
      push_entry.tangent_x = req_data.tangent_x;
      push_entry.tangent_y = req_data.tangent_y;
   end

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      have_point_in = have_point_ff || push;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         have_point_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         have_point_ff <= have_point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

   a_point_kept: assert property (@(posedge clock) disable iff (reset)
      push |=> have_point_ff)
      else $error("stored point flag not set after a word");

endmodule

[hw/rtl/hss_back.sv]
`timescale 1ns / 1ps
// Back end: t sequencer, basis weight table and multiply/sum/round pipeline.
module hss_back import hss_pkg::*; #(
   parameter int STEPS_PER_SEGMENT = STEPS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          entry_valid,
   input  hss_entry_type entry,
   output logic          entry_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output hss_rsp_type   rsp_data
);

   localparam int K_BITS   = $clog2(STEPS_PER_SEGMENT + 1);
   localparam int PAIR_BITS = PROD_BITS + 1;
   localparam int RND_BITS = SUM_BITS - FRAC_BITS;
   localparam logic [K_BITS-1:0] K_LAST = K_BITS'(STEPS_PER_SEGMENT);
   localparam longint S    = STEPS_PER_SEGMENT;
   localparam longint S3   = S * S * S;
   localparam longint DEN  = 2 * S3;
   localparam longint ONE  = longint'(1) <<< FRAC_BITS;
   localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(ONE);
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(ONE / 2);
   localparam logic signed [RND_BITS-1:0] C_MAX =
      RND_BITS'((longint'(1) <<< (COORD_BITS - 1)) - 1);
   localparam logic signed [RND_BITS-1:0] C_MIN =
      RND_BITS'(-(longint'(1) <<< (COORD_BITS - 1)));

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [RND_BITS-1:0] v
   );
      logic signed [COORD_BITS-1:0] r;
      if (v > C_MAX) begin
         r = C_MAX[COORD_BITS-1:0];
      end else if (v < C_MIN) begin
         r = C_MIN[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // weight table, one row per t = k/S, rounded floor(x + 1/2)
   hss_weight_type wtab [0:STEPS_PER_SEGMENT];

   genvar gk;
   generate
      for (gk = 0; gk <= STEPS_PER_SEGMENT; gk++) begin : g_wt
         localparam longint K  = gk;
         localparam longint N1 = 2 * (2*K*K*K - 3*K*K*S + S3) * ONE + S3;
         localparam longint N2 = 2 * (-2*K*K*K + 3*K*K*S) * ONE + S3;
         localparam longint N3 = 2 * (K*K*K - 2*K*K*S + K*S*S) * ONE + S3;
         localparam longint N4 = 2 * (K*K*K - K*K*S) * ONE + S3;
         localparam longint Q1 = N1 / DEN - ((N1 % DEN != 0 && N1 < 0) ? 1 : 0);
         localparam longint Q2 = N2 / DEN - ((N2 % DEN != 0 && N2 < 0) ? 1 : 0);
         localparam longint Q3 = N3 / DEN - ((N3 % DEN != 0 && N3 < 0) ? 1 : 0);
         localparam longint Q4 = N4 / DEN - ((N4 % DEN != 0 && N4 < 0) ? 1 : 0);
         assign wtab[gk] = '{w1: WEIGHT_BITS'(Q1), w2: WEIGHT_BITS'(Q2),
                             w3: WEIGHT_BITS'(Q3), w4: WEIGHT_BITS'(Q4)};
      end
   endgenerate

   // sequencer
   logic [K_BITS-1:0]            k_ff, k_in;
   logic [K_BITS-1:0]            k_sel;
   logic                         adv, issue, emit_sel, last_sel;
   logic signed [COORD_BITS-1:0] p0_x_ff, p0_y_ff, m0_x_ff, m0_y_ff;

   // stage 0: operands and weights
   logic                         s0_valid_ff, s0_emit_ff, s0_last_ff;
   hss_weight_type               s0_wt_ff;
   logic signed [COORD_BITS-1:0] s0_ax_ff [4];
   logic signed [COORD_BITS-1:0] s0_ay_ff [4];
   logic signed [WEIGHT_BITS-1:0] s0_w [4];

   // stage 1: products
   logic                         s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic signed [PROD_BITS-1:0]  s1_px_ff [4];
   logic signed [PROD_BITS-1:0]  s1_py_ff [4];

   // stage 2: pair sums
   logic                         s2_valid_ff, s2_emit_ff, s2_last_ff;
   logic signed [PAIR_BITS-1:0]  s2_xa_ff, s2_xb_ff, s2_ya_ff, s2_yb_ff;

   // stage 3: final sum, round, saturate
   logic signed [SUM_BITS-1:0]   sum_x, sum_y;
   logic signed [RND_BITS-1:0]   rnd_x, rnd_y;
   logic signed [COORD_BITS-1:0] smp_x, smp_y;
   logic signed [COORD_BITS-1:0] last_x_ff, last_y_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   hss_rsp_type                  rsp_data_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign issue = adv && entry_valid;

   // a curve start runs one silent t = 1 sample so the new point becomes the last sample
   always_comb begin
      k_in = k_ff;
      if (entry.start) begin
         k_sel    = K_LAST;
         emit_sel = 1'b0;
         last_sel = 1'b0;
      end else begin
         k_sel    = k_ff;
         emit_sel = 1'b1;
         last_sel = (k_ff == K_LAST);
         if (issue) begin
            k_in = (k_ff == K_LAST) ? '0 : k_ff + 1'b1;
         end
      end
      entry_pop = issue && (entry.start || (k_ff == K_LAST));
   end

   assign s0_w[0] = s0_wt_ff.w1;
   assign s0_w[1] = s0_wt_ff.w2;
   assign s0_w[2] = s0_wt_ff.w3;
   assign s0_w[3] = s0_wt_ff.w4;

   assign sum_x = SUM_BITS'(s2_xa_ff) + SUM_BITS'(s2_xb_ff) + ROUND_HALF;
   assign sum_y = SUM_BITS'(s2_ya_ff) + SUM_BITS'(s2_yb_ff) + ROUND_HALF;
   assign rnd_x = sum_x[SUM_BITS-1:FRAC_BITS];
   assign rnd_y = sum_y[SUM_BITS-1:FRAC_BITS];
   assign smp_x = sat_coord(rnd_x);
   assign smp_y = sat_coord(rnd_y);

   assign rsp_valid_in = adv ? (s2_valid_ff && s2_emit_ff) : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s0_valid_ff <= issue;
            s1_valid_ff <= s0_valid_ff;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // stored point feeds the zero-weighted terms of a curve start sample too
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_x_ff <= '0;
         p0_y_ff <= '0;
         m0_x_ff <= '0;
         m0_y_ff <= '0;
      end else if (entry_pop) begin
         p0_x_ff <= entry.point_x;
         p0_y_ff <= entry.point_y;
         m0_x_ff <= entry.tangent_x;
         m0_y_ff <= entry.tangent_y;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_emit_ff  <= emit_sel;
         s0_last_ff  <= last_sel;
         s0_wt_ff    <= wtab[k_sel];
         s0_ax_ff[0] <= p0_x_ff;
         s0_ax_ff[1] <= entry.point_x;
         s0_ax_ff[2] <= m0_x_ff;
         s0_ax_ff[3] <= entry.tangent_x;
         s0_ay_ff[0] <= p0_y_ff;
         s0_ay_ff[1] <= entry.point_y;
         s0_ay_ff[2] <= m0_y_ff;
         s0_ay_ff[3] <= entry.tangent_y;

         s1_emit_ff <= s0_emit_ff;
         s1_last_ff <= s0_last_ff;
         for (int i = 0; i < 4; i++) begin
            s1_px_ff[i] <= PROD_BITS'(s0_ax_ff[i]) * PROD_BITS'(s0_w[i]);
            s1_py_ff[i] <= PROD_BITS'(s0_ay_ff[i]) * PROD_BITS'(s0_w[i]);
         end

         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_xa_ff   <= PAIR_BITS'(s1_px_ff[0]) + PAIR_BITS'(s1_px_ff[1]);
         s2_xb_ff   <= PAIR_BITS'(s1_px_ff[2]) + PAIR_BITS'(s1_px_ff[3]);
         s2_ya_ff   <= PAIR_BITS'(s1_py_ff[0]) + PAIR_BITS'(s1_py_ff[1]);
         s2_yb_ff   <= PAIR_BITS'(s1_py_ff[2]) + PAIR_BITS'(s1_py_ff[3]);

         if (s2_valid_ff) begin
            last_x_ff <= smp_x;
            last_y_ff <= smp_y;
         end
         rsp_data_ff.from_x      <= last_x_ff;
         rsp_data_ff.from_y      <= last_y_ff;
         rsp_data_ff.to_x        <= smp_x;
         rsp_data_ff.to_y        <= smp_y;
         rsp_data_ff.last_of_run <= s2_last_ff;
      end
   end

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_LAST)
      else $error("t counter past last step");

   a_pop_on_issue: assert property (@(posedge clock) disable iff (reset)
      entry_pop |-> (entry_valid && adv && (entry.start || k_ff == K_LAST)))
      else $error("queue popped outside a final issue");

   a_end_weights: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && s0_last_ff) |->
         (s0_wt_ff.w1 == '0 && s0_wt_ff.w2 == W_ONE &&
          s0_wt_ff.w3 == '0 && s0_wt_ff.w4 == '0))
      else $error("t = 1 weights not exact");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (issue && entry.start) |=> (s0_valid_ff && !s0_emit_ff))
      else $error("curve start issued a visible line");

endmodule
